### hdl/mtcs_pkg.sv
// Shared types, constants and codes for the multi-timer compare scheduler.
`timescale 1ns / 1ps

package mtcs_pkg;

  localparam int NUM_TIMERS    = 8;
  localparam int CYCLES_PER_MS = 1000;

  localparam int SLOT_CAP = 8;
  localparam int SLOT_CNT = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;
  localparam int SLOT_AW  = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

  // compare_value / CYCLES_PER_MS as multiply by rounded-up reciprocal
  localparam int     MS_SHIFT = 16 + $clog2(CYCLES_PER_MS);
  localparam longint MS_MULT  =
    ((longint'(1) << MS_SHIFT) + longint'(CYCLES_PER_MS) - 1) / longint'(CYCLES_PER_MS);
  localparam int     MS_MUL_W = 18;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_MATCH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_NEXT    = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_ACK     = 2'd3
  } kind_e;

  typedef logic [SLOT_AW-1:0] slot_addr_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  timer_index;
    logic [30:0] load_value;
    logic        repeat_mode;
    logic [15:0] compare_value;
    logic [15:0] counter_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  expired_index;
    logic [15:0] next_compare;
    logic [31:0] elapsed_ms;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        rep;
    logic [31:0] remaining;
    logic [30:0] reload;
  } slot_t;

endpackage

### hdl/multi_timer_compare_scheduler_unit.sv
// Top level: timer table sequencer around the slot memory.
`timescale 1ns / 1ps

// Arm, cancel and unused commands stay in idle: the acknowledge appears in
// the next cycle and busy stays low. A compare match walks the slot memory
// through its single read port, one slot per cycle, then waits for the
// read-modify-write pipeline to drain and registers the final result, so
// busy is high through the walk and the drain. Expired slots are reported
// in ascending index, one per cycle, as the walk and the drain run; the
// next-compare or stop result closes the request with last set. Every
// result shows on res_o for exactly one cycle with res_valid_o high and is
// not held, so the receiver must take it then.
module multi_timer_compare_scheduler_unit import mtcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  slot_addr_t        ptr_q;
  logic [SLOT_CNT-1:0] active_q;
  logic [31:0]       ms_total_q;
  logic [15:0]       cnt_q;
  logic [16:0]       delta_q;
  logic              have_min_q;
  logic signed [31:0] min_q;
  logic              res_valid_q;
  res_t              res_q;

  // pipeline: s0 read issued, s1 difference, s2 updated time
  logic       s0_vld_q;
  slot_addr_t s0_idx_q;
  logic       s1_vld_q, s1_alive_q, s1_rep_q;
  slot_addr_t s1_idx_q;
  logic [31:0] s1_diff_q;
  logic [30:0] s1_reload_q;
  logic        s2_vld_q, s2_alive_q;
  logic signed [31:0] s2_time_q;

  logic        accept, in_range;
  slot_addr_t  req_addr;
  logic        ram_we;
  slot_addr_t  ram_waddr;
  slot_t       ram_wdata, ram_rdata;
  logic [15:0] ms_inc;
  logic        expired;
  logic [31:0] new_time;
  logic signed [32:0] nc_sum;
  logic [15:0] nc_sat;
  logic        pipe_empty;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign in_range = ({1'b0, req_i.timer_index} < 4'(SLOT_CNT));
  assign req_addr = req_i.timer_index[SLOT_AW-1:0];

  assign expired  = s1_alive_q && (s1_diff_q[31] || (s1_diff_q == 32'd0));
  assign new_time = (expired && s1_rep_q) ? s1_diff_q + {1'b0, s1_reload_q} : s1_diff_q;

  assign nc_sum = {min_q[31], min_q} + $signed({17'd0, cnt_q});
  always_comb begin
    if (nc_sum[32]) begin
      nc_sat = 16'd0;
    end else if (|nc_sum[31:16]) begin
      nc_sat = 16'hFFFF;
    end else begin
      nc_sat = nc_sum[15:0];
    end
  end

  assign pipe_empty = !s0_vld_q && !s1_vld_q && !s2_vld_q;

  always_comb begin
    if (busy) begin
      ram_we    = s1_vld_q && s1_alive_q;
      ram_waddr = s1_idx_q;
      ram_wdata = '{rep: s1_rep_q, remaining: new_time, reload: s1_reload_q};
    end else begin
      ram_we    = accept && in_range && (req_i.command == CMD_ARM);
      ram_waddr = req_addr;
      ram_wdata = '{rep: req_i.repeat_mode, remaining: {1'b0, req_i.load_value},
                    reload: req_i.load_value};
    end
  end

  mtcs_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  mtcs_ms_scaler u_ms_scaler (
    .clk_i   (clk_i),
    .load_i  (accept),
    .ticks_i (req_i.compare_value),
    .ms_o    (ms_inc)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    s0_idx_q    <= ptr_q;
    s1_idx_q    <= s0_idx_q;
    s1_alive_q  <= active_q[s0_idx_q];
    s1_rep_q    <= ram_rdata.rep;
    s1_reload_q <= ram_rdata.reload;
    s1_diff_q   <= ram_rdata.remaining - {15'd0, delta_q};
    s2_alive_q  <= s1_alive_q && !(expired && !s1_rep_q);
    s2_time_q   <= $signed(new_time);
    if (accept) begin
      cnt_q   <= req_i.counter_value;
      delta_q <= {1'b0, req_i.compare_value} + {1'b0, req_i.counter_value};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      active_q    <= '0;
      ms_total_q  <= '0;
      have_min_q  <= 1'b0;
      min_q       <= '0;
      s0_vld_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      s0_vld_q    <= (state_q == ST_SCAN);
      s1_vld_q    <= s0_vld_q;
      s2_vld_q    <= s1_vld_q;

      if (s1_vld_q && expired && !s1_rep_q) begin
        active_q[s1_idx_q] <= 1'b0;
      end

      if (s1_vld_q && expired) begin
        res_valid_q <= 1'b1;
        res_q       <= '{kind: KIND_EXPIRED, expired_index: 3'(s1_idx_q),
                         next_compare: 16'd0, elapsed_ms: ms_total_q, last: 1'b0};
      end

      if (s2_vld_q && s2_alive_q && (!have_min_q || (s2_time_q < min_q))) begin
        have_min_q <= 1'b1;
        min_q      <= s2_time_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          ptr_q <= '0;
          if (accept) begin
            if (req_i.command == CMD_MATCH) begin
              state_q    <= ST_SCAN;
              have_min_q <= 1'b0;
            end else begin
              if (in_range && (req_i.command == CMD_ARM)) begin
                active_q[req_addr] <= 1'b1;
              end else if (in_range && (req_i.command == CMD_CANCEL)) begin
                active_q[req_addr] <= 1'b0;
              end
              res_valid_q <= 1'b1;
              res_q       <= '{kind: KIND_ACK, expired_index: 3'd0, next_compare: 16'd0,
                               elapsed_ms: ms_total_q, last: 1'b1};
            end
          end
        end
        ST_SCAN: begin
          if (ptr_q == '0) begin
            ms_total_q <= ms_total_q + {16'd0, ms_inc};
          end
          if (ptr_q == SLOT_AW'(SLOT_CNT - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            ptr_q <= ptr_q + SLOT_AW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
            if (have_min_q) begin
              res_q <= '{kind: KIND_NEXT, expired_index: 3'd0, next_compare: nc_sat,
                         elapsed_ms: ms_total_q, last: 1'b1};
            end else begin
              res_q <= '{kind: KIND_STOP, expired_index: 3'd0, next_compare: 16'd0,
                         elapsed_ms: ms_total_q, last: 1'b1};
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/mtcs_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module mtcs_slot_ram import mtcs_pkg::*; (
  input  logic       clk_i,
  input  logic       we_i,
  input  slot_addr_t waddr_i,
  input  slot_t      wdata_i,
  input  slot_addr_t raddr_i,
  output slot_t      rdata_o
);

  slot_t mem [SLOT_CNT];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mtcs_ms_scaler.sv
// Converts compare ticks to whole milliseconds by reciprocal multiply.
`timescale 1ns / 1ps

module mtcs_ms_scaler import mtcs_pkg::*; (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [15:0] ticks_i,
  output logic [15:0] ms_o
);

  localparam logic [MS_MUL_W-1:0] Mult = MS_MULT[MS_MUL_W-1:0];
  localparam int ProdW = 16 + MS_MUL_W;

  logic [ProdW-1:0] prod;
  logic [15:0]      ms_q;

  assign prod = ProdW'(ticks_i) * ProdW'(Mult);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ms_q <= 16'(prod >> MS_SHIFT);
    end
  end

  assign ms_o = ms_q;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the multi-timer compare scheduler.
`timescale 1ns / 1ps

module tb;
  import mtcs_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         RAND_REQS   = 420;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_CYC   = 24;

  typedef struct {
    req_t rq;
    bit   pinned;
    res_t want;
  } plan_row_t;

  typedef struct {
    bit   on;
    res_t want;
  } pin_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  // timer table as predicted
  logic        tbl_active [SLOT_CAP];
  logic        tbl_repeat [SLOT_CAP];
  logic [31:0] tbl_left   [SLOT_CAP];
  logic [30:0] tbl_reload [SLOT_CAP];
  logic [31:0] ms_acc;

  res_t      awaited_events [$];
  pin_t      pinned_q [$];
  plan_row_t plan_q [$];

  int err_cnt     = 0;
  int n_checked   = 0;
  int n_taken     = 0;
  int n_expired   = 0;
  int n_next      = 0;
  int n_stop      = 0;
  int burst_left  = 0;
  int cycle_cnt   = 0;

  multi_timer_compare_scheduler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_cnt);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on result %0d: %s got %0h, want %0h", n_checked, what, got, want);
    err_cnt++;
  endtask

  function automatic void post_event(input kind_e kind, input logic [2:0] idx,
                                     input logic [15:0] nc, input logic last);
    res_t o;
    o.kind          = kind;
    o.expired_index = idx;
    o.next_compare  = nc;
    o.elapsed_ms    = ms_acc;
    o.last          = last;
    awaited_events.push_back(o);
  endfunction

  task automatic step_timer_table(input req_t r);
    logic [31:0] span;
    longint      low_left;
    longint      nc;
    bit          have_low;
    have_low = 1'b0;
    low_left = 0;
    if (r.command != CMD_MATCH) begin
      if (r.timer_index < SLOT_CNT) begin
        if (r.command == CMD_ARM) begin
          tbl_active[r.timer_index] = 1'b1;
          tbl_repeat[r.timer_index] = r.repeat_mode;
          tbl_left[r.timer_index]   = {1'b0, r.load_value};
          tbl_reload[r.timer_index] = r.load_value;
        end else if (r.command == CMD_CANCEL) begin
          tbl_active[r.timer_index] = 1'b0;
        end
      end
      post_event(KIND_ACK, 3'd0, 16'd0, 1'b1);
      return;
    end
    ms_acc += 32'(r.compare_value) / 32'(CYCLES_PER_MS);
    span = 32'(r.compare_value) + 32'(r.counter_value);
    for (int i = 0; i < SLOT_CNT; i++) begin
      if (tbl_active[i]) begin
        tbl_left[i] -= span;
        if ($signed(tbl_left[i]) <= 0) begin
          if (tbl_repeat[i]) tbl_left[i] += {1'b0, tbl_reload[i]};
          else tbl_active[i] = 1'b0;
          post_event(KIND_EXPIRED, 3'(i), 16'd0, 1'b0);
        end
        if (tbl_active[i] && (!have_low || longint'($signed(tbl_left[i])) < low_left)) begin
          low_left = longint'($signed(tbl_left[i]));
          have_low = 1'b1;
        end
      end
    end
    if (have_low) begin
      nc = low_left + longint'(r.counter_value);
      if (nc > 65535) nc = 65535;
      if (nc < 0) nc = 0;
      post_event(KIND_NEXT, 3'd0, 16'(nc), 1'b1);
    end else begin
      post_event(KIND_STOP, 3'd0, 16'd0, 1'b1);
    end
  endtask

  task automatic take_request(input req_t r);
    pin_t p;
    p = pinned_q.pop_front();
    step_timer_table(r);
    if (p.on) awaited_events[awaited_events.size() - 1] = p.want;
    n_taken++;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    n_checked++;
    case (got.kind)
      KIND_EXPIRED: n_expired++;
      KIND_NEXT:    n_next++;
      KIND_STOP:    n_stop++;
      default:      ;
    endcase
    if (awaited_events.size() == 0) begin
      flag_mismatch("result with nothing pending, kind", got.kind, 0);
      return;
    end
    want = awaited_events.pop_front();
    if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
    if (got.expired_index !== want.expired_index)
      flag_mismatch("expired_index", got.expired_index, want.expired_index);
    if (got.next_compare !== want.next_compare)
      flag_mismatch("next_compare", got.next_compare, want.next_compare);
    if (got.elapsed_ms !== want.elapsed_ms)
      flag_mismatch("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
    if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) check_result(res_o);
      if (start && !busy) take_request(req_i);
    end
  end

  function automatic req_t req_of(input logic [1:0] c, input logic [2:0] ix,
                                  input logic [30:0] ld, input logic rp,
                                  input logic [15:0] cv, input logic [15:0] nv);
    req_t r;
    r.command       = c;
    r.timer_index   = ix;
    r.load_value    = ld;
    r.repeat_mode   = rp;
    r.compare_value = cv;
    r.counter_value = nv;
    return r;
  endfunction

  function automatic res_t res_of(input kind_e kind, input logic [15:0] nc,
                                  input logic [31:0] ms);
    res_t o;
    o.kind          = kind;
    o.expired_index = 3'd0;
    o.next_compare  = nc;
    o.elapsed_ms    = ms;
    o.last          = 1'b1;
    return o;
  endfunction

  function automatic void add_row(input req_t rq, input bit pinned, input res_t want);
    plan_row_t row;
    row.rq     = rq;
    row.pinned = pinned;
    row.want   = want;
    plan_q.push_back(row);
  endfunction

  function automatic void build_plan();
    res_t nil;
    nil = '0;
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'hFFFF, 16'hFFFF), 1,
            res_of(KIND_STOP, 16'd0, 32'd65));
    add_row(req_of(CMD_CANCEL, 3'd7, 31'd0, 1'b0, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_SPARE, 3'd5, 31'd9, 1'b1, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_ARM, 3'd0, 31'd1, 1'b0, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd0, 16'd0), 1,
            res_of(KIND_NEXT, 16'd1, 32'd65));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd1, 16'd0), 0, nil);
    add_row(req_of(CMD_ARM, 3'd7, 31'h7FFFFFFF, 1'b1, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    // zero period, repeating: stays overdue
    add_row(req_of(CMD_ARM, 3'd3, 31'd0, 1'b1, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd999, 16'hFFFF), 0, nil);
    add_row(req_of(CMD_ARM, 3'd5, 31'd100, 1'b0, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_ARM, 3'd5, 31'd70000, 1'b1, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd65));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd1000, 16'd0), 0, nil);
    add_row(req_of(CMD_CANCEL, 3'd3, 31'd0, 1'b0, 16'd0, 16'd0), 1,
            res_of(KIND_ACK, 16'd0, 32'd66));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd0, 16'hFFFF), 0, nil);
    // fill the table so one match expires every slot
    for (int i = 0; i < 8; i++)
      add_row(req_of(CMD_ARM, 3'(i), 31'd1, i[0], 16'd0, 16'd0), 1,
              res_of(KIND_ACK, 16'd0, 32'd66));
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'd7, 16'd3), 0, nil);
    add_row(req_of(CMD_MATCH, 3'd0, 31'd0, 1'b0, 16'hFFFF, 16'd0), 0, nil);
  endfunction

  function automatic req_t rand_request();
    logic [95:0] raw;
    req_t        r;
    int unsigned pick;
    raw  = {$urandom, $urandom, $urandom};
    r    = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      r.command = CMD_ARM;
      case ($urandom_range(0, 19))
        0:       r.load_value = 31'd0;
        1, 2:    ;
        default: r.load_value = 31'($urandom_range(1, 300000));
      endcase
    end else if (pick < 55) begin
      r.command = CMD_CANCEL;
    end else if (pick < 60) begin
      r.command = CMD_SPARE;
    end else begin
      r.command = CMD_MATCH;
      if ($urandom_range(0, 3) == 0) r.counter_value = 16'($urandom_range(0, 200));
      if ($urandom_range(0, 5) == 0) r.compare_value = 16'($urandom_range(0, 200));
    end
    return r;
  endfunction

  task automatic issue(input req_t rq, input bit pinned, input res_t want);
    pin_t p;
    p.on   = pinned;
    p.want = want;
    pinned_q.push_back(p);
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_maybe();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    res_t nil;
    nil    = '0;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    ms_acc = '0;
    for (int i = 0; i < SLOT_CAP; i++) begin
      tbl_active[i] = 1'b0;
      tbl_repeat[i] = 1'b0;
      tbl_left[i]   = '0;
      tbl_reload[i] = '0;
    end
    build_plan();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      issue(plan_q[i].rq, plan_q[i].pinned, plan_q[i].want);
      pause_maybe();
    end
    for (int n = 0; n < RAND_REQS; n++) begin
      issue(rand_request(), 1'b0, nil);
      pause_maybe();
    end
    start <= 1'b0;

    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("tb: %0d requests (%0d directed) produced %0d checked results",
             n_taken, plan_q.size(), n_checked);
    $display("tb: %0d expiries, %0d next-compare and %0d stop results, %0d errors",
             n_expired, n_next, n_stop, err_cnt);
    if (err_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
